// ----- hw/rtl/cof_pkg.sv -----
package cof_pkg;

	// Field widths of the overlap word
	localparam int unsigned ModeW = 2;
	localparam int unsigned IdW = 16;
	localparam int unsigned PosFieldW = 20;

	// Defaults for the top-level parameters
	localparam int unsigned MaxReadsDef = 65536;
	localparam int unsigned PosBitsDef = 20;

	// Operation codes carried in the mode field
	localparam logic [ModeW-1:0] ModeMark = 2'd0;
	localparam logic [ModeW-1:0] ModeFilter = 2'd1;
	localparam logic [ModeW-1:0] ModeClear = 2'd2;

endpackage

// ----- hw/rtl/cof_if.sv -----
// Overlap word channel
interface cof_ovl_if;
	logic valid;
	logic ready;
	logic [cof_pkg::ModeW-1:0] mode;
	logic [cof_pkg::IdW-1:0] first_read;
	logic [cof_pkg::IdW-1:0] second_read;
	logic [cof_pkg::PosFieldW-1:0] first_start;
	logic [cof_pkg::PosFieldW-1:0] first_end;
	logic [cof_pkg::PosFieldW-1:0] first_length;
	logic [cof_pkg::PosFieldW-1:0] second_start;
	logic [cof_pkg::PosFieldW-1:0] second_end;
	logic [cof_pkg::PosFieldW-1:0] second_length;

	modport source (
		output valid, mode, first_read, second_read, first_start, first_end,
			first_length, second_start, second_end, second_length,
		input ready
	);
	modport sink (
		input valid, mode, first_read, second_read, first_start, first_end,
			first_length, second_start, second_end, second_length,
		output ready
	);
endinterface

// Result word channel
interface cof_res_if;
	logic valid;
	logic ready;
	logic keep;
	logic marked_first;
	logic marked_second;

	modport source (
		output valid, keep, marked_first, marked_second,
		input ready
	);
	modport sink (
		input valid, keep, marked_first, marked_second,
		output ready
	);
endinterface

// ----- hw/rtl/cof_bitmap.sv -----
// One-bit-wide store: one write port, two read ports, registered read data
module cof_bitmap #(
	parameter int unsigned DEPTH = cof_pkg::MaxReadsDef,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic          rd_data_a,
	output logic          rd_data_b
);

	logic mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read ports, held between reads; old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ----- hw/rtl/contained_overlap_filter_core.sv -----
// A taken overlap word passes through stage 1 and the output register before its
// result word is valid. Throughput: one overlap word per cycle while the result
// channel is not stalled; the single bitmap read-modify-write with write-to-read
// forwarding sets this. Reset: arst_n clears control at once, then a sweep zeroes
// the bitmap one entry a cycle over all MAX_READS entries, during which ovl.ready stays low.
module contained_overlap_filter_core #(
	parameter int unsigned MAX_READS = cof_pkg::MaxReadsDef,
	parameter int unsigned POS_BITS = cof_pkg::PosBitsDef
) (
	input logic    clk,
	input logic    arst_n,
	cof_ovl_if.sink   ovl,
	cof_res_if.source res
);

	localparam int unsigned AW = $clog2(MAX_READS);
	localparam int unsigned CmpW = ((AW > cof_pkg::IdW) ? AW : cof_pkg::IdW) + 1;
	localparam int unsigned PosW =
		(POS_BITS < cof_pkg::PosFieldW) ? POS_BITS : cof_pkg::PosFieldW;
	localparam int unsigned HW = PosW + 2;

	// Clearing sweep
	logic [AW-1:0] clr_addr_q;
	logic          clr_done_q;

	// Stage 1: item waiting on bitmap read data
	logic                      s1_valid_q;
	logic [cof_pkg::ModeW-1:0] mode_s1;
	logic [AW-1:0]             addr_a_s1;
	logic [AW-1:0]             addr_b_s1;
	logic                      a_in_s1;
	logic                      b_in_s1;
	logic                      mark_a_s1;
	logic                      mark_b_s1;
	logic                      fwd_a_s1;
	logic                      fwd_b_s1;
	logic                      fwd_d_s1;

	// Output register
	logic res_valid_q;
	logic keep_q;
	logic marked_first_q;
	logic marked_second_q;

	logic accept;
	logic s1_adv;
	logic s1_fire;

	// Id decode
	logic [CmpW-1:0] id_a_ext;
	logic [CmpW-1:0] id_b_ext;
	logic            a_in;
	logic            b_in;

	// Forced hangs
	logic signed [HW-1:0] a_lo;
	logic signed [HW-1:0] a_hi;
	logic signed [HW-1:0] a_len;
	logic signed [HW-1:0] b_lo;
	logic signed [HW-1:0] b_hi;
	logic signed [HW-1:0] b_len;
	logic signed [HW-1:0] h1;
	logic signed [HW-1:0] h2;
	logic                 mark_a;
	logic                 mark_b;

	// Bitmap ports
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;
	logic          rd_data_a;
	logic          rd_data_b;
	logic          bit_a;
	logic          bit_b;

	// Handshake
	assign s1_adv = !res_valid_q || res.ready;
	assign s1_fire = s1_valid_q && s1_adv;
	assign ovl.ready = clr_done_q && (!s1_valid_q || s1_adv);
	assign accept = ovl.valid && ovl.ready;

	assign id_a_ext = CmpW'(ovl.first_read);
	assign id_b_ext = CmpW'(ovl.second_read);
	assign a_in = id_a_ext < CmpW'(MAX_READS);
	assign b_in = id_b_ext < CmpW'(MAX_READS);

	// Hangs over the low PosW bits of each position
	assign a_lo = HW'(ovl.first_start[PosW-1:0]);
	assign a_hi = HW'(ovl.first_end[PosW-1:0]);
	assign a_len = HW'(ovl.first_length[PosW-1:0]);
	assign b_lo = HW'(ovl.second_start[PosW-1:0]);
	assign b_hi = HW'(ovl.second_end[PosW-1:0]);
	assign b_len = HW'(ovl.second_length[PosW-1:0]);
	assign h1 = a_lo - b_lo;
	assign h2 = (b_len - b_hi) - (a_len - a_hi);
	assign mark_a = (h1 <= 0) && (h2 >= 0);
	assign mark_b = !mark_a && (h1 >= 0) && (h2 <= 0);

	// Write port: sweep during clear, else stage 1 update
	always_comb begin
		wr_en = 1'b0;
		wr_addr = addr_a_s1;
		wr_data = 1'b0;
		if (!clr_done_q) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
		end else if (s1_fire) begin
			case (mode_s1)
				cof_pkg::ModeMark: begin
					if (mark_a_s1) begin
						wr_en = a_in_s1;
						wr_data = 1'b1;
					end else if (mark_b_s1) begin
						wr_en = b_in_s1;
						wr_addr = addr_b_s1;
						wr_data = 1'b1;
					end
				end
				cof_pkg::ModeClear: begin
					wr_en = a_in_s1;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	cof_bitmap #(
		.DEPTH (MAX_READS)
	) u_bitmap (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (accept),
		.rd_addr_a (id_a_ext[AW-1:0]),
		.rd_addr_b (id_b_ext[AW-1:0]),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// Read data with the colliding write forwarded
	assign bit_a = fwd_a_s1 ? fwd_d_s1 : rd_data_a;
	assign bit_b = fwd_b_s1 ? fwd_d_s1 : rd_data_b;

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_READS - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= ovl.mode;
			addr_a_s1 <= id_a_ext[AW-1:0];
			addr_b_s1 <= id_b_ext[AW-1:0];
			a_in_s1 <= a_in;
			b_in_s1 <= b_in;
			mark_a_s1 <= mark_a;
			mark_b_s1 <= mark_b;
			fwd_a_s1 <= wr_en && (wr_addr == id_a_ext[AW-1:0]);
			fwd_b_s1 <= wr_en && (wr_addr == id_b_ext[AW-1:0]);
			fwd_d_s1 <= wr_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			case (mode_s1)
				cof_pkg::ModeMark: begin
					keep_q <= 1'b0;
					marked_first_q <= mark_a_s1;
					marked_second_q <= mark_b_s1;
				end
				cof_pkg::ModeFilter: begin
					keep_q <= !((a_in_s1 && bit_a) || (b_in_s1 && bit_b));
					marked_first_q <= 1'b0;
					marked_second_q <= 1'b0;
				end
				default: begin
					keep_q <= 1'b0;
					marked_first_q <= 1'b0;
					marked_second_q <= 1'b0;
				end
			endcase
		end
	end

	assign res.valid = res_valid_q;
	assign res.keep = keep_q;
	assign res.marked_first = marked_first_q;
	assign res.marked_second = marked_second_q;

endmodule
